// File: rtl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg: shared constants for the ray / tetrahedron intersection block
// Fixed-point format, opcodes, divider step count and the face corner table.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [0:0] OP_LOAD = 1'b0;
  localparam logic [0:0] OP_CAST = 1'b1;

  // restoring divider: 128 numerator bits plus the fraction bits
  localparam int DIV_STEPS = 128 + FRAC_BITS;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  // corners of each face, first corner is the plane anchor
  function automatic logic [1:0] face_corner(input logic [1:0] face, input logic [1:0] idx);
    logic [5:0] row;
    case (face)
      2'd0:    row = {2'd3, 2'd2, 2'd1};
      2'd1:    row = {2'd2, 2'd3, 2'd0};
      2'd2:    row = {2'd1, 2'd0, 2'd3};
      default: row = {2'd0, 2'd1, 2'd2};
    endcase
    case (idx)
      2'd0:    return row[5:4];
      2'd1:    return row[3:2];
      default: return row[1:0];
    endcase
  endfunction

endpackage

// File: rtl/ray_tetrahedron_intersect.sv
// ----------------------------------------------------------------------------
// ray_tetrahedron_intersect: ray / tetrahedron face-clipping intersection
// Vertex store, sequencer and datapath around one shared multiplier and
// one shared divider.
// ----------------------------------------------------------------------------
// A load beat (opcode 0) writes one corner. A cast beat (opcode 1) clips the
// ray against the four face planes in order and yields either one miss beat
// or an entry beat followed by an exit beat (last_item marks the final beat).
// Every product goes through the shared 64x16 multiplier and every t and
// barycentric value goes through the shared bit-serial divider. A face scan
// runs microprogram steps 0 to 11 and at most one divide; each hit beat runs
// steps 0 to 29 and two divides. The input is ready only when the sequencer
// is idle; a result beat may still be waiting at the output while the next
// item is taken. Corners read before any load hold unknown data.
module ray_tetrahedron_intersect (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [0:0]          opcode,
  input  logic [1:0]          vertex_slot,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [31:0]  dir_x,
  input  logic signed [31:0]  dir_y,
  input  logic signed [31:0]  dir_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                hit,
  output logic                last_item,
  output logic [1:0]          face_index,
  output logic signed [31:0]  point_x,
  output logic signed [31:0]  point_y,
  output logic signed [31:0]  point_z,
  output logic signed [31:0]  bary_u,
  output logic signed [31:0]  bary_v,
  output logic signed [31:0]  ray_param
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_MAC, S_WB, S_DECIDE, S_DIVT, S_NEXT,
    S_DIVU, S_DIVV, S_OUT, S_MISS
  } state_t;

  typedef enum logic [4:0] {
    WB_NONE, WB_NX, WB_NY, WB_NZ, WB_VD, WB_VN, WB_P0, WB_P1, WB_P2,
    WB_C1X, WB_C1Y, WB_C1Z, WB_C2X, WB_C2Y, WB_C2Z, WB_DEN, WB_NUM1, WB_NUM2
  } wb_t;

  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic               sub;
    logic               clr;
    wb_t                wb;
  } op_t;

  function automatic logic signed [31:0] sat32(input logic signed [127:0] x);
    if (x > $signed(128'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (x < -$signed(128'sh8000_0000)) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  state_t              state;
  logic [1:0]          face;
  logic [1:0]          fcnt;
  logic [4:0]          step;
  logic                emitting;
  logic                last_flag;
  logic                have_e;
  logic                have_l;
  logic                mul_pend;
  logic [1:0]          ef;
  logic [1:0]          lf;
  logic signed [63:0]  te;
  logic signed [63:0]  tl;
  logic signed [63:0]  t_cur;

  logic signed [31:0]  org [3];
  logic signed [31:0]  dir [3];
  logic signed [31:0]  va [3];
  logic signed [31:0]  vb [3];
  logic signed [31:0]  vcur [3];
  logic signed [32:0]  ab [3];
  logic signed [32:0]  ac [3];
  logic signed [32:0]  w [3];
  logic signed [63:0]  nrm [3];
  logic signed [63:0]  c1 [3];
  logic signed [63:0]  c2 [3];
  logic signed [31:0]  p [3];
  logic signed [127:0] vd;
  logic signed [127:0] vn;
  logic signed [127:0] den;
  logic signed [127:0] num1;
  logic signed [127:0] num2;
  logic signed [127:0] acc;
  logic signed [31:0]  bu;
  logic signed [31:0]  bv;

  logic [95:0]         vstore [4];
  logic [95:0]         vrd;
  logic [1:0]          raddr;

  logic                in_acc;
  logic                load_acc;
  logic                out_free;
  logic                vn_pos;
  op_t                 op;
  logic signed [127:0] base;
  logic signed [127:0] acc_new;
  logic signed [127:0] acc_shr;
  logic signed [31:0]  pt_org;
  logic signed [31:0]  pnew;

  logic                mul_start;
  logic                mul_done;
  logic signed [127:0] mul_res;
  logic                div_start;
  logic signed [127:0] div_num;
  logic signed [127:0] div_den;
  logic                div_done;
  logic signed [63:0]  div_q;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign load_acc  = in_acc && (opcode == rti_pkg::OP_LOAD);
  assign out_free  = !out_valid || out_ready;
  assign vn_pos    = !vn[127] && (vn != '0);
  assign raddr     = rti_pkg::face_corner(face, fcnt);
  assign vcur[0]   = vrd[95:64];
  assign vcur[1]   = vrd[63:32];
  assign vcur[2]   = vrd[31:0];
  assign mul_start = (state == S_MAC) && !mul_pend;

  // corner store
  always_ff @(posedge clk) begin
    if (load_acc) begin
      vstore[vertex_slot] <= {pos_x, pos_y, pos_z};
    end
    vrd <= vstore[raddr];
  end

  // microprogram: steps 0-5 build the face normal, then either the two
  // plane dots (scan) or point, cross terms and barycentric dots (emit)
  always_comb begin
    op    = '0;
    op.wb = WB_NONE;
    case (step)
      5'd0: begin op.a = 64'(ab[1]); op.b = 64'(ac[2]); op.clr = 1'b1; end
      5'd1: begin op.a = 64'(ab[2]); op.b = 64'(ac[1]); op.sub = 1'b1; op.wb = WB_NX; end
      5'd2: begin op.a = 64'(ab[2]); op.b = 64'(ac[0]); op.clr = 1'b1; end
      5'd3: begin op.a = 64'(ab[0]); op.b = 64'(ac[2]); op.sub = 1'b1; op.wb = WB_NY; end
      5'd4: begin op.a = 64'(ab[0]); op.b = 64'(ac[1]); op.clr = 1'b1; end
      5'd5: begin op.a = 64'(ab[1]); op.b = 64'(ac[0]); op.sub = 1'b1; op.wb = WB_NZ; end
      5'd6: begin
        if (emitting) begin
          op.a = t_cur; op.b = 64'(dir[0]); op.clr = 1'b1; op.wb = WB_P0;
        end else begin
          op.a = 64'(dir[0]); op.b = nrm[0]; op.clr = 1'b1;
        end
      end
      5'd7: begin
        if (emitting) begin
          op.a = t_cur; op.b = 64'(dir[1]); op.clr = 1'b1; op.wb = WB_P1;
        end else begin
          op.a = 64'(dir[1]); op.b = nrm[1];
        end
      end
      5'd8: begin
        if (emitting) begin
          op.a = t_cur; op.b = 64'(dir[2]); op.clr = 1'b1; op.wb = WB_P2;
        end else begin
          op.a = 64'(dir[2]); op.b = nrm[2]; op.wb = WB_VD;
        end
      end
      5'd9: begin
        if (emitting) begin
          op.a = 64'(w[1]); op.b = 64'(ac[2]); op.clr = 1'b1;
        end else begin
          op.a = 64'(w[0]); op.b = nrm[0]; op.clr = 1'b1;
        end
      end
      5'd10: begin
        if (emitting) begin
          op.a = 64'(w[2]); op.b = 64'(ac[1]); op.sub = 1'b1; op.wb = WB_C1X;
        end else begin
          op.a = 64'(w[1]); op.b = nrm[1];
        end
      end
      5'd11: begin
        if (emitting) begin
          op.a = 64'(w[2]); op.b = 64'(ac[0]); op.clr = 1'b1;
        end else begin
          op.a = 64'(w[2]); op.b = nrm[2]; op.wb = WB_VN;
        end
      end
      5'd12: begin op.a = 64'(w[0]); op.b = 64'(ac[2]); op.sub = 1'b1; op.wb = WB_C1Y; end
      5'd13: begin op.a = 64'(w[0]); op.b = 64'(ac[1]); op.clr = 1'b1; end
      5'd14: begin op.a = 64'(w[1]); op.b = 64'(ac[0]); op.sub = 1'b1; op.wb = WB_C1Z; end
      5'd15: begin op.a = 64'(ab[1]); op.b = 64'(w[2]); op.clr = 1'b1; end
      5'd16: begin op.a = 64'(ab[2]); op.b = 64'(w[1]); op.sub = 1'b1; op.wb = WB_C2X; end
      5'd17: begin op.a = 64'(ab[2]); op.b = 64'(w[0]); op.clr = 1'b1; end
      5'd18: begin op.a = 64'(ab[0]); op.b = 64'(w[2]); op.sub = 1'b1; op.wb = WB_C2Y; end
      5'd19: begin op.a = 64'(ab[0]); op.b = 64'(w[1]); op.clr = 1'b1; end
      5'd20: begin op.a = 64'(ab[1]); op.b = 64'(w[0]); op.sub = 1'b1; op.wb = WB_C2Z; end
      5'd21: begin op.a = nrm[0]; op.b = nrm[0]; op.clr = 1'b1; end
      5'd22: begin op.a = nrm[1]; op.b = nrm[1]; end
      5'd23: begin op.a = nrm[2]; op.b = nrm[2]; op.wb = WB_DEN; end
      5'd24: begin op.a = c1[0]; op.b = nrm[0]; op.clr = 1'b1; end
      5'd25: begin op.a = c1[1]; op.b = nrm[1]; end
      5'd26: begin op.a = c1[2]; op.b = nrm[2]; op.wb = WB_NUM1; end
      5'd27: begin op.a = c2[0]; op.b = nrm[0]; op.clr = 1'b1; end
      5'd28: begin op.a = c2[1]; op.b = nrm[1]; end
      5'd29: begin op.a = c2[2]; op.b = nrm[2]; op.wb = WB_NUM2; end
      default: ;
    endcase
  end

  always_comb begin
    base    = op.clr ? 128'sd0 : acc;
    acc_new = op.sub ? (base - mul_res) : (base + mul_res);
    acc_shr = acc >>> rti_pkg::FRAC_BITS;
    case (op.wb)
      WB_P1:   pt_org = org[1];
      WB_P2:   pt_org = org[2];
      default: pt_org = org[0];
    endcase
    pnew = sat32(acc_shr + 128'(pt_org));
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = num1;
    div_den   = den;
    case (state)
      S_DECIDE: begin
        if (vd != '0) begin
          div_start = 1'b1;
          div_num   = -vn;
          div_den   = vd;
        end
      end
      S_WB: begin
        if (op.wb == WB_NUM2) begin
          div_start = 1'b1;
        end
      end
      S_DIVU: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = num2;
        end
      end
      default: ;
    endcase
  end

  rti_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (op.a),
    .b     (op.b),
    .done  (mul_done),
    .prod  (mul_res)
  );

  rti_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mul_pend  <= 1'b0;
      face      <= '0;
      fcnt      <= '0;
      step      <= '0;
      emitting  <= 1'b0;
      last_flag <= 1'b0;
      have_e    <= 1'b0;
      have_l    <= 1'b0;
    end else begin
      // the output states reload the register themselves
      if (out_valid && out_ready && !(state inside {S_OUT, S_MISS})) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && opcode == rti_pkg::OP_CAST) begin
            org[0]   <= pos_x;
            org[1]   <= pos_y;
            org[2]   <= pos_z;
            dir[0]   <= dir_x;
            dir[1]   <= dir_y;
            dir[2]   <= dir_z;
            face     <= '0;
            fcnt     <= '0;
            have_e   <= 1'b0;
            have_l   <= 1'b0;
            emitting <= 1'b0;
            state    <= S_FETCH;
          end
        end
        S_FETCH: begin
          // corner reads are registered: data arrives the cycle after its address
          fcnt <= fcnt + 1'b1;
          case (fcnt)
            2'd0: ;
            2'd1: begin
              for (int k = 0; k < 3; k++) va[k] <= vcur[k];
            end
            2'd2: begin
              for (int k = 0; k < 3; k++) vb[k] <= vcur[k];
            end
            default: begin
              for (int k = 0; k < 3; k++) begin
                ab[k] <= 33'(vb[k]) - 33'(va[k]);
                ac[k] <= 33'(vcur[k]) - 33'(va[k]);
                w[k]  <= 33'(org[k]) - 33'(va[k]);
              end
              step  <= '0;
              state <= S_MAC;
            end
          endcase
        end
        S_MAC: begin
          if (mul_start) begin
            mul_pend <= 1'b1;
          end else if (mul_done) begin
            mul_pend <= 1'b0;
            acc      <= acc_new;
            if (op.wb != WB_NONE) begin
              state <= S_WB;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        S_WB: begin
          case (op.wb)
            WB_NX:   nrm[0] <= acc_shr[63:0];
            WB_NY:   nrm[1] <= acc_shr[63:0];
            WB_NZ:   nrm[2] <= acc_shr[63:0];
            WB_VD:   vd <= acc;
            WB_VN:   vn <= acc;
            WB_P0:   begin p[0] <= pnew; w[0] <= 33'(pnew) - 33'(va[0]); end
            WB_P1:   begin p[1] <= pnew; w[1] <= 33'(pnew) - 33'(va[1]); end
            WB_P2:   begin p[2] <= pnew; w[2] <= 33'(pnew) - 33'(va[2]); end
            WB_C1X:  c1[0] <= acc_shr[63:0];
            WB_C1Y:  c1[1] <= acc_shr[63:0];
            WB_C1Z:  c1[2] <= acc_shr[63:0];
            WB_C2X:  c2[0] <= acc_shr[63:0];
            WB_C2Y:  c2[1] <= acc_shr[63:0];
            WB_C2Z:  c2[2] <= acc_shr[63:0];
            WB_DEN:  den <= acc;
            WB_NUM1: num1 <= acc;
            WB_NUM2: num2 <= acc;
            default: ;
          endcase
          if (op.wb == WB_VN) begin
            state <= S_DECIDE;
          end else if (op.wb == WB_NUM2) begin
            state <= S_DIVU;
          end else begin
            step  <= step + 1'b1;
            state <= S_MAC;
          end
        end
        S_DECIDE: begin
          // ray parallel to the plane: outside is a miss, else skip face
          if (vd == '0) begin
            state <= vn_pos ? S_MISS : S_NEXT;
          end else begin
            state <= S_DIVT;
          end
        end
        S_DIVT: begin
          if (div_done) begin
            if (vd[127]) begin
              if (have_l && div_q > tl) begin
                state <= S_MISS;
              end else begin
                if (!have_e || div_q > te) begin
                  te     <= div_q;
                  ef     <= face;
                  have_e <= 1'b1;
                end
                state <= S_NEXT;
              end
            end else begin
              if (have_e && div_q < te) begin
                state <= S_MISS;
              end else begin
                if (!have_l || div_q < tl) begin
                  tl     <= div_q;
                  lf     <= face;
                  have_l <= 1'b1;
                end
                state <= S_NEXT;
              end
            end
          end
        end
        S_NEXT: begin
          fcnt <= '0;
          if (face != 2'd3) begin
            face  <= face + 1'b1;
            state <= S_FETCH;
          end else if (have_e && have_l) begin
            emitting  <= 1'b1;
            face      <= ef;
            t_cur     <= te;
            last_flag <= 1'b0;
            state     <= S_FETCH;
          end else begin
            state <= S_MISS;
          end
        end
        S_DIVU: begin
          if (div_done) begin
            bu    <= sat32(128'(div_q));
            state <= S_DIVV;
          end
        end
        S_DIVV: begin
          if (div_done) begin
            bv    <= sat32(128'(div_q));
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            hit        <= 1'b1;
            last_item  <= last_flag;
            face_index <= face;
            point_x    <= p[0];
            point_y    <= p[1];
            point_z    <= p[2];
            bary_u     <= bu;
            bary_v     <= bv;
            ray_param  <= sat32(128'(t_cur));
            if (last_flag) begin
              emitting <= 1'b0;
              state    <= S_IDLE;
            end else begin
              face      <= lf;
              t_cur     <= tl;
              last_flag <= 1'b1;
              fcnt      <= '0;
              state     <= S_FETCH;
            end
          end
        end
        S_MISS: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            hit        <= 1'b0;
            last_item  <= 1'b1;
            face_index <= '0;
            point_x    <= '0;
            point_y    <= '0;
            point_z    <= '0;
            bary_u     <= '0;
            bary_v     <= '0;
            ray_param  <= '0;
            emitting   <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/rti_mul.sv
// ----------------------------------------------------------------------------
// rti_mul: shared signed 64x64 multiplier
// Sign-magnitude, one 64x16 partial product per cycle, 128-bit result.
// ----------------------------------------------------------------------------
module rti_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [63:0]   a,
  input  logic signed [63:0]   b,
  output logic                 done,
  output logic signed [127:0]  prod
);

  localparam int CHUNK = 16;
  localparam int STEPS = 64 / CHUNK;
  localparam int CW    = $clog2(STEPS + 1);

  logic [63:0]   ua;
  logic [63:0]   ub;
  logic          neg;
  logic [127:0]  p;
  logic [CW-1:0] cnt;
  logic          fin;
  logic [79:0]   pp;

  always_comb begin
    pp = ua * ub[63 -: CHUNK];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      fin  <= 1'b0;
      done <= fin;
      if (fin) begin
        prod <= neg ? (128'd0 - p) : p;
      end
      if (start) begin
        ua  <= a[63] ? (64'd0 - $unsigned(a)) : $unsigned(a);
        ub  <= b[63] ? (64'd0 - $unsigned(b)) : $unsigned(b);
        neg <= a[63] ^ b[63];
        p   <= '0;
        cnt <= CW'(STEPS);
      end else if (cnt != '0) begin
        // top chunk first, Horner style
        p   <= (p << CHUNK) + 128'(pp);
        ub  <= ub << CHUNK;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          fin <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div: shared fixed-point divider
// Restoring, one quotient bit per cycle; truncates toward zero and
// saturates the quotient to +/-(2^63-1). Zero divisor gives zero.
// ----------------------------------------------------------------------------
module rti_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [127:0]  num,
  input  logic signed [127:0]  den,
  output logic                 done,
  output logic signed [63:0]   quo
);

  logic [127:0]                 nsh;
  logic [127:0]                 dm;
  logic [127:0]                 r;
  logic [63:0]                  q;
  logic                         sat;
  logic                         neg;
  logic                         zero;
  logic [rti_pkg::DIV_CW-1:0]   cnt;
  logic                         fin;
  logic [128:0]                 r2;
  logic                         ge;
  logic [63:0]                  qm;

  always_comb begin
    r2 = {r, nsh[127]};
    ge = r2 >= {1'b0, dm};
    qm = zero ? 64'd0 : (sat ? {1'b0, {63{1'b1}}} : q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      fin  <= 1'b0;
      done <= fin;
      if (fin) begin
        quo <= neg ? (64'd0 - qm) : qm;
      end
      if (start) begin
        nsh  <= num[127] ? (128'd0 - $unsigned(num)) : $unsigned(num);
        dm   <= den[127] ? (128'd0 - $unsigned(den)) : $unsigned(den);
        r    <= '0;
        q    <= '0;
        sat  <= 1'b0;
        neg  <= num[127] ^ den[127];
        zero <= (den == '0);
        cnt  <= rti_pkg::DIV_CW'(rti_pkg::DIV_STEPS);
      end else if (cnt != '0) begin
        nsh <= nsh << 1;
        // remainder stays below the divisor, so 128 bits hold it
        r   <= ge ? 128'(r2 - {1'b0, dm}) : r2[127:0];
        if (!sat) begin
          if (q[63:62] != 2'b00) begin
            sat <= 1'b1;
          end else begin
            q <= {q[62:0], ge};
          end
        end
        cnt <= cnt - 1'b1;
        if (cnt == rti_pkg::DIV_CW'(1)) begin
          fin <= 1'b1;
        end
      end
    end
  end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: ray / tetrahedron intersection block testbench
// Directed table of corner loads and casts, then random tetrahedra with rays aimed
// through them plus full-range noise. Every accepted result beat is checked against
// an in-bench fixed-point face-clipping predictor, or a miss beat for table misses.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          Q         = 1 << rti_pkg::FRAC_BITS;
  localparam longint      CYC_LIMIT = 60_000_000;
  localparam logic signed [31:0] PMAX = 32'sh7fffffff;
  localparam logic signed [31:0] PMIN = 32'sh80000000;

  typedef logic signed [63:0] vec_t [3];

  typedef struct packed {
    logic              hit;
    logic              last;
    logic [1:0]        face;
    logic signed [31:0] px, py, pz, u, v, t;
  } beat_t;

  typedef struct {
    logic [0:0]         op;
    logic [1:0]         slot;
    logic signed [31:0] px, py, pz, dx, dy, dz;
    bit                 typed_miss;
  } row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [0:0] opcode;
  logic [1:0] vertex_slot;
  logic signed [31:0] pos_x, pos_y, pos_z, dir_x, dir_y, dir_z;
  logic hit, last_item;
  logic [1:0] face_index;
  logic signed [31:0] point_x, point_y, point_z, bary_u, bary_v, ray_param;

  ray_tetrahedron_intersect u_top (.*);

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // corners of each face, anchor first
  const int unsigned CORNER [4][3] = '{'{3, 2, 1}, '{2, 3, 0}, '{1, 0, 3}, '{0, 1, 2}};

  logic signed [63:0] corners [4][3];
  beat_t   pending_beats [$];
  int      fails = 0;
  longint  cycles = 0;
  int      src_idle, snk_stall;

  // ---------------- predictor arithmetic ----------------
  function automatic logic signed [63:0] sat64(logic signed [127:0] x);
    if (x[127:63] != {65{x[127]}})
      return x[127] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
    return x[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [127:0] x);
    if (x[127:31] != {97{x[127]}}) return x[127] ? PMIN : PMAX;
    return x[31:0];
  endfunction

  function automatic logic signed [127:0] mulw(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [127:0] ea, eb;
    ea = a;
    eb = b;
    return ea * eb;
  endfunction

  // quotient with FRAC_BITS fraction bits, toward zero, saturated to 63 bits
  function automatic logic signed [63:0] divq(logic signed [127:0] num,
                                              logic signed [127:0] den);
    logic [127:0] n, d;
    logic [127+rti_pkg::FRAC_BITS:0] nn, qq;
    logic [63:0] q;
    if (den == 0) return 0;
    n  = num[127] ? -num : num;
    d  = den[127] ? -den : den;
    nn = {n, {rti_pkg::FRAC_BITS{1'b0}}};
    qq = nn / d;
    q  = (qq[127+rti_pkg::FRAC_BITS:63] != 0) ? 64'h7fffffffffffffff : qq[63:0];
    return (num[127] ^ den[127]) ? -q : q;
  endfunction

  function automatic void cross_q(input vec_t a, input vec_t b, output vec_t o);
    o[0] = sat64((mulw(a[1], b[2]) - mulw(a[2], b[1])) >>> rti_pkg::FRAC_BITS);
    o[1] = sat64((mulw(a[2], b[0]) - mulw(a[0], b[2])) >>> rti_pkg::FRAC_BITS);
    o[2] = sat64((mulw(a[0], b[1]) - mulw(a[1], b[0])) >>> rti_pkg::FRAC_BITS);
  endfunction

  function automatic logic signed [127:0] dotw(input vec_t a, input vec_t b);
    return mulw(a[0], b[0]) + mulw(a[1], b[1]) + mulw(a[2], b[2]);
  endfunction

  function automatic void face_geom(input int f, output vec_t anchor, output vec_t ab,
                                    output vec_t ac, output vec_t nrm);
    for (int k = 0; k < 3; k++) begin
      anchor[k] = corners[CORNER[f][0]][k];
      ab[k] = corners[CORNER[f][1]][k] - anchor[k];
      ac[k] = corners[CORNER[f][2]][k] - anchor[k];
    end
    cross_q(ab, ac, nrm);
  endfunction

  function automatic beat_t face_beat(int f, logic signed [63:0] t, vec_t o, vec_t d, bit last);
    vec_t anchor, ab, ac, nrm, p, ap, c1, c2;
    logic signed [127:0] den;
    beat_t b;
    face_geom(f, anchor, ab, ac, nrm);
    for (int k = 0; k < 3; k++) begin
      p[k]  = sat32(128'(o[k]) + (mulw(t, d[k]) >>> rti_pkg::FRAC_BITS));
      ap[k] = p[k] - anchor[k];
    end
    cross_q(ap, ac, c1);
    cross_q(ab, ap, c2);
    den = dotw(nrm, nrm);
    b.hit = 1'b1;
    b.last = last;
    b.face = f[1:0];
    b.px = p[0][31:0];
    b.py = p[1][31:0];
    b.pz = p[2][31:0];
    b.u = sat32(divq(dotw(c1, nrm), den));
    b.v = sat32(divq(dotw(c2, nrm), den));
    b.t = sat32(t);
    return b;
  endfunction

  function automatic beat_t miss_beat();
    beat_t b;
    b = '0;
    b.last = 1'b1;
    return b;
  endfunction

  // clip the ray against the four face planes, queue the beats it yields
  function automatic void predict_cast(vec_t o, vec_t d);
    vec_t anchor, ab, ac, nrm, rel;
    logic signed [127:0] vd, vn;
    logic signed [63:0] t, t_in, t_out;
    int f_in, f_out;
    bit got_in, got_out;
    t_in = 0; t_out = 0; f_in = 0; f_out = 0; got_in = 0; got_out = 0;
    for (int f = 0; f < 4; f++) begin
      face_geom(f, anchor, ab, ac, nrm);
      for (int k = 0; k < 3; k++) rel[k] = o[k] - anchor[k];
      vd = dotw(d, nrm);
      vn = dotw(rel, nrm);
      if (vd == 0) begin
        if (vn > 0) begin
          pending_beats.push_back(miss_beat());
          return;
        end
        continue;
      end
      t = divq(-vn, vd);
      if (vd < 0) begin
        if (got_out && t > t_out) begin
          pending_beats.push_back(miss_beat());
          return;
        end
        if (!got_in || t > t_in) begin t_in = t; f_in = f; got_in = 1; end
      end else begin
        if (got_in && t < t_in) begin
          pending_beats.push_back(miss_beat());
          return;
        end
        if (!got_out || t < t_out) begin t_out = t; f_out = f; got_out = 1; end
      end
    end
    if (!got_in || !got_out) begin
      pending_beats.push_back(miss_beat());
      return;
    end
    pending_beats.push_back(face_beat(f_in, t_in, o, d, 0));
    pending_beats.push_back(face_beat(f_out, t_out, o, d, 1));
  endfunction

  // ---------------- driving ----------------
  task automatic send(row_t r);
    vec_t o, d;
    while ($urandom_range(99) < src_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = r.op; vertex_slot = r.slot;
    pos_x = r.px; pos_y = r.py; pos_z = r.pz;
    dir_x = r.dx; dir_y = r.dy; dir_z = r.dz;
    do @(posedge clk); while (!in_ready);
    o = '{64'(r.px), 64'(r.py), 64'(r.pz)};
    d = '{64'(r.dx), 64'(r.dy), 64'(r.dz)};
    if (r.op == rti_pkg::OP_LOAD) begin
      for (int k = 0; k < 3; k++) corners[r.slot][k] = o[k];
    end else if (r.typed_miss) begin
      pending_beats.push_back(miss_beat());
    end else begin
      predict_cast(o, d);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
  endtask

  function automatic row_t mk(logic [0:0] op, logic [1:0] slot,
                              logic signed [31:0] px, py, pz, dx, dy, dz, bit tm = 0);
    row_t r;
    r.op = op; r.slot = slot; r.px = px; r.py = py; r.pz = pz;
    r.dx = dx; r.dy = dy; r.dz = dz; r.typed_miss = tm;
    return r;
  endfunction

  function automatic logic signed [31:0] rnd_full();
    return $urandom();
  endfunction

  // coordinate within +-span
  function automatic logic signed [31:0] rnd_in(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // random or kept tetrahedron, then a few rays mostly aimed through its middle, or one noise beat
  task automatic random_group(ref int items);
    vec_t c;
    int span, casts;
    logic signed [31:0] ox, oy, oz;
    span = ($urandom_range(9) == 0) ? (1 << 28) : (($urandom_range(3) + 1) * 16 * Q);
    if ($urandom_range(9) == 0) begin
      send(mk($urandom_range(1) ? rti_pkg::OP_CAST : rti_pkg::OP_LOAD, 2'($urandom_range(3)),
              rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full()));
      items++;
      return;
    end
    if ($urandom_range(3) != 0) begin
      for (int s = 0; s < 4; s++) begin
        send(mk(rti_pkg::OP_LOAD, 2'(s), rnd_in(span), rnd_in(span), rnd_in(span),
                rnd_full(), rnd_full(), rnd_full()));
        items++;
      end
    end
    c = '{0, 0, 0};
    for (int s = 0; s < 4; s++)
      for (int k = 0; k < 3; k++) c[k] += corners[s][k];
    casts = $urandom_range(3) + 1;
    for (int i = 0; i < casts; i++) begin
      ox = rnd_in(span); oy = rnd_in(span); oz = rnd_in(span);
      if ($urandom_range(4) == 0)
        send(mk(rti_pkg::OP_CAST, 2'($urandom_range(3)), ox, oy, oz,
                rnd_in(span), rnd_in(span), rnd_in(span)));
      else
        send(mk(rti_pkg::OP_CAST, 2'($urandom_range(3)), ox, oy, oz,
                32'(c[0] / 4 - ox) + rnd_in(Q),
                32'(c[1] / 4 - oy) + rnd_in(Q), 32'(c[2] / 4 - oz) + rnd_in(Q)));
      items++;
    end
  endtask

  // ---------------- checking ----------------
  always @(posedge clk) begin
    beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat");
        fails++;
      end else begin
        e = pending_beats.pop_front();
        if (hit !== e.hit) begin $error("hit exp %0d got %0d", e.hit, hit); fails++; end
        if (last_item !== e.last) begin
          $error("last_item exp %0d got %0d", e.last, last_item); fails++;
        end
        if (face_index !== e.face) begin
          $error("face_index exp %0d got %0d", e.face, face_index); fails++;
        end
        if (point_x !== e.px) begin $error("point_x exp %0d got %0d", e.px, point_x); fails++; end
        if (point_y !== e.py) begin $error("point_y exp %0d got %0d", e.py, point_y); fails++; end
        if (point_z !== e.pz) begin $error("point_z exp %0d got %0d", e.pz, point_z); fails++; end
        if (bary_u !== e.u) begin $error("bary_u exp %0d got %0d", e.u, bary_u); fails++; end
        if (bary_v !== e.v) begin $error("bary_v exp %0d got %0d", e.v, bary_v); fails++; end
        if (ray_param !== e.t) begin
          $error("ray_param exp %0d got %0d", e.t, ray_param); fails++;
        end
      end
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= snk_stall);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    row_t dir_rows [$];
    int items;
    items = 0;
    src_idle = 0; snk_stall = 0;
    in_valid = 0; opcode = rti_pkg::OP_LOAD; vertex_slot = 0;
    pos_x = 0; pos_y = 0; pos_z = 0; dir_x = 0; dir_y = 0; dir_z = 0;
    for (int s = 0; s < 4; s++) for (int k = 0; k < 3; k++) corners[s][k] = 0;
    rst = 1'b1;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    dir_rows = '{
      mk(rti_pkg::OP_LOAD, 2'd0, 0, 0, 0, 0, 0, 0),
      mk(rti_pkg::OP_LOAD, 2'd1, Q, 0, 0, 0, 0, 0),
      mk(rti_pkg::OP_LOAD, 2'd2, 0, Q, 0, 0, 0, 0),
      mk(rti_pkg::OP_LOAD, 2'd3, 0, 0, Q, 0, 0, 0),
      mk(rti_pkg::OP_CAST, 2'd0, Q / 8, Q / 8, -Q, 0, 0, Q),
      mk(rti_pkg::OP_CAST, 2'd0, -Q, Q / 4, Q / 4, Q, 0, 0),
      mk(rti_pkg::OP_CAST, 2'd0, 5 * Q, 5 * Q, 5 * Q, 0, 0, 0, 1),   // zero direction
      mk(rti_pkg::OP_CAST, 2'd0, Q / 4, Q / 4, Q / 4, Q, Q, Q),
      mk(rti_pkg::OP_CAST, 2'd0, 2 * Q, 2 * Q, -Q, 0, 0, Q),  // parallel to faces, outside
      mk(rti_pkg::OP_CAST, 2'd0, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN),
      mk(rti_pkg::OP_CAST, 2'd0, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX),
      mk(rti_pkg::OP_LOAD, 2'd0, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN),
      mk(rti_pkg::OP_LOAD, 2'd1, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX),
      mk(rti_pkg::OP_LOAD, 2'd2, PMAX, PMIN, 0, 0, 0, 0),
      mk(rti_pkg::OP_LOAD, 2'd3, 0, PMAX, PMIN, 0, 0, 0),
      mk(rti_pkg::OP_CAST, 2'd0, 0, 0, 0, 1, 1, 1),
      mk(rti_pkg::OP_CAST, 2'd0, PMAX, PMIN, PMAX, 0, 0, 0, 1),
      mk(rti_pkg::OP_LOAD, 2'd0, Q, Q, Q, 0, 0, 0),            // all corners at one point
      mk(rti_pkg::OP_LOAD, 2'd1, Q, Q, Q, 0, 0, 0),
      mk(rti_pkg::OP_LOAD, 2'd2, Q, Q, Q, 0, 0, 0),
      mk(rti_pkg::OP_LOAD, 2'd3, Q, Q, Q, 0, 0, 0),
      mk(rti_pkg::OP_CAST, 2'd3, 0, 0, 0, Q, Q, Q, 1)          // degenerate faces skipped
    };
    foreach (dir_rows[i]) begin
      send(dir_rows[i]);
      items++;
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 77; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 77; end
        default: begin src_idle = 26; snk_stall = 26; end
      endcase
      while (items < 22 + 432 * (ph + 1)) begin
        random_group(items);
        // now and then hold off until the block has emptied
        if ($urandom_range(31) == 0) drain();
      end
      drain();
    end

    drain();
    repeat (200) @(negedge clk);
    if (fails == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

// File: sim.f
rtl/rti_pkg.sv
rtl/rti_mul.sv
rtl/rti_div.sv
rtl/ray_tetrahedron_intersect.sv
bench/tb_top.sv
